// File: design/bps_pkg.sv
// ----------------------------------------------------------------------------
// bps_pkg
// Shared types and constants for the byte pattern search unit.
// ----------------------------------------------------------------------------
`default_nettype none

package bps_pkg;

  localparam int BYTE_W        = 8;
  localparam int PATTERN_SLOTS = 16;
  localparam int LEN_W         = 5;
  localparam int CFG_DATA_W    = 64;
  localparam int CFG_INDEX_W   = 2;
  localparam int OFFSET_OUT_W  = 32;

  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LOW  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_HIGH = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LEN  = 2'd2;

  typedef logic [BYTE_W-1:0] byte_t;

  typedef struct packed {
    logic advance;
    logic clear;
  } bps_cell_ctrl_t;

endpackage

`default_nettype wire

// File: design/bps_cell.sv
// ----------------------------------------------------------------------------
// bps_cell
// One window cell: holds a past byte, passes it on, compares it to its
// aligned pattern byte.
// ----------------------------------------------------------------------------
`default_nettype none

module bps_cell
  import bps_pkg::*;
(
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire bps_cell_ctrl_t ctrl,
  input  wire byte_t          byte_in,
  input  wire byte_t          pattern_byte,
  output byte_t               byte_out,
  output logic                match
);

  byte_t stored;

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      stored <= '0;
    end else if (ctrl.advance) begin
      stored <= byte_in;
    end
  end

  assign byte_out = stored;
  assign match    = (stored == pattern_byte);

endmodule

`default_nettype wire

// File: design/byte_pattern_search_unit.sv
// A result sits in the output register from the cycle after its final
// or matching byte beat is accepted.
// Throughput: one byte beat per cycle; cells shift on non-final beats.
// s_tready drops only while a result waits in the output register.
// Reset clears config, window, byte count, match flag and output valid.
// ----------------------------------------------------------------------------
// byte_pattern_search_unit
// Streaming substring search over a shifting chain of byte cells.
// ----------------------------------------------------------------------------
`default_nettype none

module byte_pattern_search_unit
  import bps_pkg::*;
#(
  parameter int MAX_PATTERN = 16,
  parameter int OFFSET_BITS = 32
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    s_tvalid,
  output logic                         s_tready,
  input  wire logic [7:0]              s_tdata,   // [7:0] data_byte
  input  wire logic                    s_tlast,   // area_end
  output logic                         m_tvalid,
  input  wire logic                    m_tready,
  output logic [OFFSET_OUT_W-1:0]      m_tdata,   // [31:0] match_offset
  output logic                         m_tuser,   // [0] found
  input  wire logic                    cfg_we,
  input  wire logic [CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0]   cfg_data
);

  logic [CFG_DATA_W-1:0] pattern_low;
  logic [CFG_DATA_W-1:0] pattern_high;
  logic [LEN_W-1:0]      pattern_len;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_low  <= '0;
      pattern_high <= '0;
      pattern_len  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PATTERN_LOW:  pattern_low  <= cfg_data;
        REG_PATTERN_HIGH: pattern_high <= cfg_data;
        REG_PATTERN_LEN:  pattern_len  <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  byte_t pattern_arr [PATTERN_SLOTS];
  byte_t window      [MAX_PATTERN];
  byte_t aligned     [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] eq;
  logic [MAX_PATTERN-1:0] needed;
  logic [LEN_W-1:0]       len_m1;

  logic                   accept;
  logic                   len_ok;
  logic                   count_ok;
  logic                   hit;
  logic                   emit;
  logic [OFFSET_BITS-1:0] bytes_seen;
  logic                   match_reported;
  logic [OFFSET_BITS-1:0] offset_full;
  logic [OFFSET_OUT_W-1:0] offset_out;
  bps_cell_ctrl_t         cell_ctrl;

  assign len_m1 = pattern_len - LEN_W'(1);

  always_comb begin
    for (int i = 0; i < PATTERN_SLOTS / 2; i++) begin
      pattern_arr[i]                     = pattern_low[i*BYTE_W +: BYTE_W];
      pattern_arr[i + PATTERN_SLOTS / 2] = pattern_high[i*BYTE_W +: BYTE_W];
    end
  end

  assign window[0] = s_tdata[BYTE_W-1:0];
  assign eq[0]     = (window[0] == aligned[0]);

  genvar w;
  generate
    for (w = 0; w < MAX_PATTERN; w++) begin : g_pos
      logic [LEN_W-1:0] idx;
      assign idx        = len_m1 - LEN_W'(w);
      assign needed[w]  = (LEN_W'(w) < pattern_len);
      assign aligned[w] = pattern_arr[idx[3:0]];
      if (w > 0) begin : g_cell
        bps_cell u_cell (
          .clk          (clk),
          .rst          (rst),
          .ctrl         (cell_ctrl),
          .byte_in      (window[w-1]),
          .pattern_byte (aligned[w]),
          .byte_out     (window[w]),
          .match        (eq[w])
        );
      end
    end
  endgenerate

  assign accept   = s_tvalid && s_tready;
  assign len_ok   = (pattern_len != '0) && (pattern_len <= LEN_W'(MAX_PATTERN));
  assign count_ok = (bytes_seen >= OFFSET_BITS'(len_m1));
  assign hit      = !match_reported && len_ok && count_ok && ((eq | ~needed) == '1);
  assign emit     = hit || (s_tlast && !match_reported);

  assign offset_full = bytes_seen - OFFSET_BITS'(len_m1);

  generate
    if (OFFSET_BITS >= OFFSET_OUT_W) begin : g_off_trunc
      assign offset_out = offset_full[OFFSET_OUT_W-1:0];
    end else begin : g_off_ext
      assign offset_out = {{(OFFSET_OUT_W - OFFSET_BITS){1'b0}}, offset_full};
    end
  endgenerate

  assign cell_ctrl.advance = accept && !s_tlast;
  assign cell_ctrl.clear   = accept && s_tlast;

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_seen     <= '0;
      match_reported <= 1'b0;
    end else if (accept) begin
      if (s_tlast) begin
        bytes_seen     <= '0;
        match_reported <= 1'b0;
      end else begin
        if (bytes_seen != '1) begin
          bytes_seen <= bytes_seen + OFFSET_BITS'(1);
        end
        if (hit) begin
          match_reported <= 1'b1;
        end
      end
    end
  end

  assign s_tready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_tready) begin
      m_tvalid <= accept && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      m_tuser <= hit;
      m_tdata <= hit ? offset_out : '0;
    end
  end

  a_not_found_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> (m_tdata == '0))
    else $error("not-found result carries a non-zero offset");

  a_clear_on_end: assert property (@(posedge clk) disable iff (rst)
    (accept && s_tlast) |=> ((bytes_seen == '0) && !match_reported))
    else $error("area state not cleared after final beat");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (accept && !s_tlast && (bytes_seen != '1))
      |=> (bytes_seen == $past(bytes_seen) + OFFSET_BITS'(1)))
    else $error("byte count did not advance on beat");

endmodule

`default_nettype wire
